// ----- rtl/jt_pkg.sv -----
// jt_pkg: shared constants, state encoding and command/status structs
// for the permutation step unit; no dependencies
package jt_pkg;

	localparam int MAX_ELEMENTS = 8;
	localparam int VAL_W        = 4;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int SIZE_W       = 4;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_ELEMENTS);

	localparam logic DIR_LEFT  = 1'b0;
	localparam logic DIR_RIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWAP,
		ST_FLIP,
		ST_EMIT,
		ST_FIN
	} jt_state_t;

	typedef struct packed {
		logic load_id;
		logic find;
		logic move;
		logic flip;
		logic clr_idx;
		logic emit_elem;
		logic emit_fin;
	} jt_cmd_t;

	typedef struct packed {
		logic found;
		logic idx_last;
		logic out_free;
	} jt_sts_t;

endpackage

// ----- rtl/jt_dpath.sv -----
// jt_dpath: permutation and direction registers, mobile search, swap,
// direction flip and the result register; uses jt_pkg
module jt_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [jt_pkg::SIZE_W-1:0]    cfg_wr_data,
	input  jt_pkg::jt_cmd_t              cmd,
	output jt_pkg::jt_sts_t              sts,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [jt_pkg::VAL_W-1:0]     element_value,
	output logic [jt_pkg::IDX_W-1:0]     position,
	output logic                         last,
	output logic                         finished
);

	logic [jt_pkg::MAX_ELEMENTS-1:0][jt_pkg::VAL_W-1:0] perm_q;
	logic [jt_pkg::MAX_ELEMENTS-1:0]                    dir_q;
	logic [jt_pkg::SIZE_W-1:0]                          size_q;
	logic [jt_pkg::IDX_W-1:0]                           best_q;
	logic                                               found_q;
	logic [jt_pkg::VAL_W-1:0]                           moved_q;
	logic [jt_pkg::IDX_W-1:0]                           idx_q;
	logic                                               out_valid_q;
	logic [jt_pkg::VAL_W-1:0]                           value_q;
	logic [jt_pkg::IDX_W-1:0]                           pos_q;
	logic                                               last_q;
	logic                                               fin_q;

	logic [jt_pkg::CNT_W-1:0]  n_act;
	logic [jt_pkg::IDX_W-1:0]  last_idx;
	logic [jt_pkg::IDX_W-1:0]  best_c;
	logic                      found_c;
	logic [jt_pkg::IDX_W-1:0]  swap_idx;

	always_comb begin
		if (size_q == '0) begin
			n_act = jt_pkg::CNT_W'(1);
		end else if (jt_pkg::CNT_W'(size_q) > jt_pkg::CNT_W'(jt_pkg::MAX_ELEMENTS)) begin
			n_act = jt_pkg::CNT_W'(jt_pkg::MAX_ELEMENTS);
		end else begin
			n_act = jt_pkg::CNT_W'(size_q);
		end
		last_idx = jt_pkg::IDX_W'(n_act - jt_pkg::CNT_W'(1));
	end

	// largest mobile element over the active positions
	always_comb begin
		logic [jt_pkg::VAL_W-1:0] best_v;
		logic                     mob;
		best_v  = '0;
		best_c  = '0;
		found_c = 1'b0;
		for (int i = 0; i < jt_pkg::MAX_ELEMENTS; i++) begin
			mob = 1'b0;
			if (dir_q[i] == jt_pkg::DIR_LEFT) begin
				mob = (i > 0) &&
					(perm_q[i] > perm_q[jt_pkg::IDX_W'(i - 1)]);
			end else begin
				mob = (jt_pkg::CNT_W'(i + 1) < n_act) &&
					(perm_q[i] > perm_q[jt_pkg::IDX_W'(i + 1)]);
			end
			if ((jt_pkg::CNT_W'(i) < n_act) && mob && (perm_q[i] > best_v)) begin
				best_v  = perm_q[i];
				best_c  = jt_pkg::IDX_W'(i);
				found_c = 1'b1;
			end
		end
	end

	assign swap_idx = (dir_q[best_q] == jt_pkg::DIR_LEFT) ? best_q - 1'b1 : best_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= jt_pkg::SIZE_RESET;
			for (int i = 0; i < jt_pkg::MAX_ELEMENTS; i++) begin
				perm_q[i] <= jt_pkg::VAL_W'(i + 1);
			end
			dir_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			if (cfg_wr_en || cmd.load_id) begin
				for (int i = 0; i < jt_pkg::MAX_ELEMENTS; i++) begin
					perm_q[i] <= jt_pkg::VAL_W'(i + 1);
				end
				dir_q <= '0;
			end else if (cmd.move) begin
				perm_q[best_q]   <= perm_q[swap_idx];
				perm_q[swap_idx] <= perm_q[best_q];
				dir_q[best_q]    <= dir_q[swap_idx];
				dir_q[swap_idx]  <= dir_q[best_q];
			end else if (cmd.flip) begin
				for (int i = 0; i < jt_pkg::MAX_ELEMENTS; i++) begin
					if ((jt_pkg::CNT_W'(i) < n_act) && (perm_q[i] > moved_q)) begin
						dir_q[i] <= ~dir_q[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cmd.find) begin
				found_q <= found_c;
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.emit_elem) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.find) begin
			best_q <= best_c;
		end
		if (cmd.move) begin
			moved_q <= perm_q[best_q];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_elem || cmd.emit_fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_elem) begin
			value_q <= perm_q[idx_q];
			pos_q   <= idx_q;
			last_q  <= (idx_q == last_idx);
			fin_q   <= 1'b0;
		end else if (cmd.emit_fin) begin
			value_q <= '0;
			pos_q   <= '0;
			last_q  <= 1'b1;
			fin_q   <= 1'b1;
		end
	end

	assign sts.found    = found_q;
	assign sts.idx_last = (idx_q == last_idx);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign element_value = value_q;
	assign position      = pos_q;
	assign last          = last_q;
	assign finished      = fin_q;

`ifndef SYNTHESIS
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.find |=> (!found_q || (best_q <= last_idx)))
		else $error("mobile index beyond active size");

	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_elem && (idx_q == last_idx)) |=> (last_q && !fin_q))
		else $error("final element not tagged last");

	a_fin_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fin |=> (fin_q && last_q && (value_q == '0) && (pos_q == '0)))
		else $error("malformed finished report");

	a_flip_keeps_perm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flip && !cfg_wr_en) |=> $stable(perm_q))
		else $error("permutation changed during direction flip");
`endif

endmodule

// ----- rtl/jt_ctrl.sv -----
// jt_ctrl: sequencer for scan, swap, flip and result emission
// uses jt_pkg state and command/status types
module jt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            restart,
	input  jt_pkg::jt_sts_t sts,
	output jt_pkg::jt_cmd_t cmd
);

	jt_pkg::jt_state_t state_q;
	jt_pkg::jt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			jt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (restart) begin
						cmd.load_id = 1'b1;
						cmd.clr_idx = 1'b1;
						state_d     = jt_pkg::ST_EMIT;
					end else begin
						state_d = jt_pkg::ST_SCAN;
					end
				end
			end
			jt_pkg::ST_SCAN: begin
				cmd.find = 1'b1;
				state_d  = jt_pkg::ST_SWAP;
			end
			jt_pkg::ST_SWAP: begin
				if (sts.found) begin
					cmd.move = 1'b1;
					state_d  = jt_pkg::ST_FLIP;
				end else begin
					state_d = jt_pkg::ST_FIN;
				end
			end
			jt_pkg::ST_FLIP: begin
				cmd.flip    = 1'b1;
				cmd.clr_idx = 1'b1;
				state_d     = jt_pkg::ST_EMIT;
			end
			jt_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_elem = 1'b1;
					if (sts.idx_last) begin
						state_d = jt_pkg::ST_IDLE;
					end
				end
			end
			jt_pkg::ST_FIN: begin
				if (sts.out_free) begin
					cmd.emit_fin = 1'b1;
					state_d      = jt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = jt_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_id, cmd.find, cmd.move, cmd.flip, cmd.emit_elem, cmd.emit_fin}))
		else $error("more than one datapath operation at once");

	a_swap_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> $past(cmd.find))
		else $error("swap without a preceding scan");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_elem || cmd.emit_fin) |-> sts.out_free)
		else $error("result loaded while output register busy");
`endif

endmodule

// ----- rtl/johnson_trotter_permutation_step_unit.sv -----
// johnson_trotter_permutation_step_unit: top level of the permutation
// step unit; instantiates jt_ctrl and jt_dpath, uses jt_pkg
//
// input channel: in_valid/in_stall carry one restart bit per transaction.
//   restart=1 loads the identity 1..n with all directions left and emits it;
//   restart=0 moves the largest mobile element one place, reverses the
//   direction of all larger elements and emits the new permutation.
// output channel: out_valid/out_stall carry one position per transaction,
//   positions 0..n-1 in order, last set on position n-1. with no mobile
//   element a single transaction with finished=1, last=1, value 0 is sent.
// config: cfg_wr_en writes size_in_use (0 acts as 1, above 8 acts as 8)
//   and reloads the identity; write only while the unit is idle.
// sequence: a restart that is accepted loads the identity and goes straight
//   to emission; an advance first steps through scan, swap, flip and load.
//   results then leave one per cycle while out_stall is low, all through
//   the one result register. in_stall is high while an item is being
//   worked on
// a stalled receiver holds the output register and pauses emission
//   without losing results.
// reset: size 8, identity permutation, all directions left, no output valid.
module johnson_trotter_permutation_step_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [jt_pkg::SIZE_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       restart,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [jt_pkg::VAL_W-1:0]   element_value,
	output logic [jt_pkg::IDX_W-1:0]   position,
	output logic                       last,
	output logic                       finished
);

	jt_pkg::jt_cmd_t cmd;
	jt_pkg::jt_sts_t sts;

	jt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.sts      (sts),
		.cmd      (cmd)
	);

	jt_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.element_value (element_value),
		.position      (position),
		.last          (last),
		.finished      (finished)
	);

endmodule
